// ===== src/assert_macros.svh =====
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is asserted
`define AMI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ===== src/ami_pkg.sv =====
package ami_pkg;

  localparam int unsigned ElemW = 32;
  localparam int unsigned DataW = 6 * ElemW;
  localparam int unsigned Lanes = 4;

  typedef struct packed {
    logic [ElemW-1:0] tx;
    logic [ElemW-1:0] ty;
    logic             sing;
    logic             shrt;
  } side_t;

  function automatic logic [ElemW-1:0] abs32(input logic [ElemW-1:0] x);
    return x[ElemW-1] ? (~x + 1'b1) : x;
  endfunction

endpackage

// ===== src/affine_matrix_inverse_core.sv =====
// Affine 2x3 matrix inverse, signed fixed point, FRAC_BITS fraction bits.
// Slave stream: one matrix per transaction, tdata = a, b, c, d, tx, ty
// (32 bits each, a lowest). Master stream: inverse in the same layout,
// tuser = singular (all tdata bits zero when set).
// Divisions round to nearest, ties away from zero; quotients wrap at 32 bits.
// Pipeline stages: input register, determinant products, divider load,
// one restoring divider stage per quotient bit (32 + 2*FRAC_BITS stages,
// four lanes side by side), quotient rounding, translation products,
// translation sum and final rounding into the output register.
// Throughput is one matrix per cycle while the output is not stalled; the whole pipeline advances together.
// When the receiver holds tready low with a result waiting, every stage
// holds and s_axis_tready_o falls in the same cycle; nothing is lost or
// repeated. While the output register is empty the pipeline keeps moving,
// so bubbles travel through it with the data.
// Reset clears all valid bits; the pipeline starts empty and ready.
module affine_matrix_inverse_core #(
  parameter int unsigned FRAC_BITS = 11
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // a, b, c, d, tx, ty from bit 0 up
  input  logic [ami_pkg::DataW-1:0] s_axis_tdata_i,
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  // out_a, out_b, out_c, out_d, out_tx, out_ty from bit 0 up
  output logic [ami_pkg::DataW-1:0] m_axis_tdata_o,
  // singular
  output logic                     m_axis_tuser_o
);

  localparam int unsigned W  = ami_pkg::ElemW;
  localparam int unsigned L  = ami_pkg::Lanes;
  localparam int unsigned NW = W + 2 * FRAC_BITS;
  localparam logic [63:0] Half = 64'd1 << (FRAC_BITS - 1);

  logic adv;
  logic vout_q;

  assign adv             = !vout_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // input register
  logic         v0_q;
  logic [W-1:0] a0_q, b0_q, c0_q, d0_q, tx0_q, ty0_q;

  // determinant products
  logic         v1_q;
  logic [W-1:0] a1_q, b1_q, c1_q, d1_q, tx1_q, ty1_q, ad1_q, bc1_q;

  // divider chain
  logic           vd_q  [NW+1];
  ami_pkg::side_t sd_q  [NW+1];
  logic [L-1:0]   qn_q  [NW+1];
  logic [W-1:0]   rem_q [NW+1][L];
  logic [NW-1:0]  nq_q  [NW+1][L];
  logic [W-1:0]   dm_q  [NW+1][L];
  logic [W-1:0]   rem_d [NW+1][L];
  logic [NW-1:0]  nq_d  [NW+1][L];

  // post-divider stages
  logic           vq_q, vm_q, vs_q;
  ami_pkg::side_t sq_q, sm_q, ss_q;
  logic [W-1:0]   oq_q [L];
  logic [W-1:0]   om_q [L];
  logic [W-1:0]   os_q [L];
  logic [63:0]    pm_q [L];
  logic [63:0]    ps_q [2];

  logic [ami_pkg::DataW-1:0] tdata_q;
  logic                      sing_q;

  // front-end selection
  logic           scl, swp;
  logic [W-1:0]   det;
  logic [W-1:0]   xmag [L];
  logic [L-1:0]   nsg, dsg;
  logic [W-1:0]   dmg  [L];
  logic           sing;

  always_comb begin
    scl = (b1_q == '0) && (c1_q == '0);
    swp = !scl && (a1_q == '0) && (d1_q == '0);
    det = ad1_q - bc1_q;
    xmag[0] = ami_pkg::abs32(d1_q);
    xmag[1] = ami_pkg::abs32(b1_q);
    xmag[2] = ami_pkg::abs32(c1_q);
    xmag[3] = ami_pkg::abs32(a1_q);
    nsg     = {a1_q[W-1], !c1_q[W-1], !b1_q[W-1], d1_q[W-1]};
    for (int l = 0; l < L; l++) begin
      dmg[l] = ami_pkg::abs32(det);
    end
    dsg  = {L{det[W-1]}};
    sing = (det == '0);
    if (scl) begin
      xmag[0] = W'(1);
      xmag[1] = '0;
      xmag[2] = '0;
      xmag[3] = W'(1);
      nsg     = '0;
      dmg[0]  = ami_pkg::abs32(a1_q);
      dmg[1]  = W'(1);
      dmg[2]  = W'(1);
      dmg[3]  = ami_pkg::abs32(d1_q);
      dsg     = {d1_q[W-1], 1'b0, 1'b0, a1_q[W-1]};
      sing    = (a1_q == '0) || (d1_q == '0);
    end else if (swp) begin
      xmag[0] = '0;
      xmag[1] = W'(1);
      xmag[2] = W'(1);
      xmag[3] = '0;
      nsg     = '0;
      dmg[0]  = W'(1);
      dmg[1]  = ami_pkg::abs32(c1_q);
      dmg[2]  = ami_pkg::abs32(b1_q);
      dmg[3]  = W'(1);
      dsg     = {1'b0, b1_q[W-1], c1_q[W-1], 1'b0};
      sing    = (b1_q == '0) || (c1_q == '0);
    end
  end

  // one restoring step per stage
  always_comb begin
    logic [W:0] r2;
    for (int k = 0; k <= NW; k++) begin
      for (int l = 0; l < L; l++) begin
        rem_d[k][l] = rem_q[k][l];
        nq_d[k][l]  = nq_q[k][l];
      end
    end
    for (int k = 0; k < NW; k++) begin
      for (int l = 0; l < L; l++) begin
        r2 = {rem_q[k][l], nq_q[k][l][NW-1]};
        if (r2 >= {1'b0, dm_q[k][l]}) begin
          rem_d[k][l] = W'(r2 - {1'b0, dm_q[k][l]});
          nq_d[k][l]  = {nq_q[k][l][NW-2:0], 1'b1};
        end else begin
          rem_d[k][l] = r2[W-1:0];
          nq_d[k][l]  = {nq_q[k][l][NW-2:0], 1'b0};
        end
      end
    end
  end

  // quotient rounding
  logic [W-1:0] oq_d [L];
  always_comb begin
    logic [W-1:0] q;
    for (int l = 0; l < L; l++) begin
      q = nq_q[NW][l][W-1:0];
      if ({rem_q[NW][l], 1'b0} >= {1'b0, dm_q[NW][l]}) begin
        q = q + 1'b1;
      end
      oq_d[l] = qn_q[NW][l] ? (~q + 1'b1) : q;
    end
  end

  // translation sums
  logic [63:0] ps_d [2];
  always_comb begin
    ps_d[0] = 64'd0 - pm_q[0] - pm_q[2];
    ps_d[1] = 64'd0 - pm_q[1] - pm_q[3];
    if (sm_q.shrt) begin
      ps_d[0] = {{32{ps_d[0][31]}}, ps_d[0][31:0]};
      ps_d[1] = {{32{ps_d[1][31]}}, ps_d[1][31:0]};
    end
  end

  // division by ONE, rounded
  logic [W-1:0] tr_d [2];
  always_comb begin
    logic [63:0] mag;
    logic [63:0] q;
    for (int i = 0; i < 2; i++) begin
      mag     = ps_q[i][63] ? (~ps_q[i] + 1'b1) : ps_q[i];
      q       = (mag + Half) >> FRAC_BITS;
      tr_d[i] = ps_q[i][63] ? (~q[W-1:0] + 1'b1) : q[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      vq_q   <= 1'b0;
      vm_q   <= 1'b0;
      vs_q   <= 1'b0;
      vout_q <= 1'b0;
      for (int k = 0; k <= NW; k++) begin
        vd_q[k] <= 1'b0;
      end
    end else if (adv) begin
      v0_q    <= s_axis_tvalid_i;
      v1_q    <= v0_q;
      vd_q[0] <= v1_q;
      for (int k = 1; k <= NW; k++) begin
        vd_q[k] <= vd_q[k-1];
      end
      vq_q   <= vd_q[NW];
      vm_q   <= vq_q;
      vs_q   <= vm_q;
      vout_q <= vs_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a0_q  <= s_axis_tdata_i[0*W +: W];
      b0_q  <= s_axis_tdata_i[1*W +: W];
      c0_q  <= s_axis_tdata_i[2*W +: W];
      d0_q  <= s_axis_tdata_i[3*W +: W];
      tx0_q <= s_axis_tdata_i[4*W +: W];
      ty0_q <= s_axis_tdata_i[5*W +: W];

      a1_q  <= a0_q;
      b1_q  <= b0_q;
      c1_q  <= c0_q;
      d1_q  <= d0_q;
      tx1_q <= tx0_q;
      ty1_q <= ty0_q;
      ad1_q <= W'(a0_q * d0_q);
      bc1_q <= W'(b0_q * c0_q);

      sd_q[0] <= '{tx: tx1_q, ty: ty1_q, sing: sing, shrt: scl || swp};
      qn_q[0] <= nsg ^ dsg;
      for (int l = 0; l < L; l++) begin
        rem_q[0][l] <= '0;
        nq_q[0][l]  <= {xmag[l], {(2 * FRAC_BITS){1'b0}}};
        dm_q[0][l]  <= dmg[l];
      end
      for (int k = 1; k <= NW; k++) begin
        sd_q[k] <= sd_q[k-1];
        qn_q[k] <= qn_q[k-1];
        for (int l = 0; l < L; l++) begin
          rem_q[k][l] <= rem_d[k-1][l];
          nq_q[k][l]  <= nq_d[k-1][l];
          dm_q[k][l]  <= dm_q[k-1][l];
        end
      end

      sq_q <= sd_q[NW];
      oq_q <= oq_d;

      sm_q     <= sq_q;
      om_q     <= oq_q;
      pm_q[0]  <= $signed(sq_q.tx) * $signed(oq_q[0]);
      pm_q[1]  <= $signed(sq_q.tx) * $signed(oq_q[1]);
      pm_q[2]  <= $signed(sq_q.ty) * $signed(oq_q[2]);
      pm_q[3]  <= $signed(sq_q.ty) * $signed(oq_q[3]);

      ss_q <= sm_q;
      os_q <= om_q;
      ps_q <= ps_d;

      sing_q  <= ss_q.sing;
      tdata_q <= ss_q.sing ? '0 : {tr_d[1], tr_d[0], os_q[3], os_q[2], os_q[1], os_q[0]};
    end
  end

  assign m_axis_tvalid_o = vout_q;
  assign m_axis_tdata_o  = tdata_q;
  assign m_axis_tuser_o  = sing_q;

endmodule

// ===== src/ami_checker.sv =====
`include "assert_macros.svh"

module ami_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid_i,
  input logic                      s_axis_tready_o,
  input logic [ami_pkg::DataW-1:0] s_axis_tdata_i,
  input logic                      m_axis_tvalid_o,
  input logic                      m_axis_tready_i,
  input logic [ami_pkg::DataW-1:0] m_axis_tdata_o,
  input logic                      m_axis_tuser_o
);

  `AMI_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o, "result dropped under stall")
  `AMI_ASSERT(a_out_stable, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "result changed under stall")
  `AMI_ASSERT(a_sing_zero, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == '0, "singular result not zero")
  `AMI_ASSERT(a_ready_follow, clk_i, rst_ni, m_axis_tready_i |-> s_axis_tready_o, "input stalled with output free")
  `AMI_ASSERT(a_empty_ready, clk_i, rst_ni, !m_axis_tvalid_o |-> s_axis_tready_o, "input stalled with output empty")

endmodule

bind affine_matrix_inverse_core ami_checker u_ami_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// ===== test/ami_checker.sv =====
`timescale 1ns / 100ps

module ami_scoreboard #(
  parameter int unsigned FRAC_BITS = 11
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_valid_i,
  input  logic                      s_ready_i,
  input  logic [ami_pkg::DataW-1:0] s_data_i,
  input  logic                      m_valid_i,
  input  logic                      m_ready_i,
  input  logic [ami_pkg::DataW-1:0] m_data_i,
  input  logic                      m_user_i,
  output int                        fail_count_o,
  output int                        pending_o
);

  typedef struct packed {
    logic                      sing;
    logic [ami_pkg::DataW-1:0] data;
  } inverse_t;

  inverse_t inverse_q[$];
  int       fails;

  assign fail_count_o = fails;
  assign pending_o    = inverse_q.size();

  // rounded division, ties away from zero, low 32 bits of the quotient
  function automatic logic [31:0] div_round(input logic signed [63:0] num,
                                            input logic signed [31:0] den);
    logic [63:0] nmag, dmag, q, r;
    nmag = num[63] ? -num : num;
    dmag = den[31] ? 64'(-$signed(64'(den))) : 64'(den);
    if (dmag == 0) return '0;
    q = nmag / dmag;
    r = nmag % dmag;
    if (2 * r >= dmag) q = q + 1;
    if (num[63] != den[31]) q = -q;
    return q[31:0];
  endfunction

  function automatic inverse_t invert(input logic [ami_pkg::DataW-1:0] m);
    logic signed [31:0] a, b, c, d, tx, ty, det, one;
    logic signed [63:0] one2;
    logic        [31:0] o[6];
    logic        [31:0] w;
    logic               sing;
    inverse_t           res;
    a = m[31:0]; b = m[63:32]; c = m[95:64];
    d = m[127:96]; tx = m[159:128]; ty = m[191:160];
    one  = 32'sd1 <<< FRAC_BITS;
    one2 = 64'sd1 <<< (2 * FRAC_BITS);
    sing = 1'b0;
    for (int k = 0; k < 6; k++) o[k] = '0;
    if (b == 0 && c == 0) begin
      if (a == 0 || d == 0) sing = 1'b1;
      else begin
        o[0] = div_round(one2, a);
        o[3] = div_round(one2, d);
        w = -(tx * o[0]); o[4] = div_round(64'($signed(w)), one);
        w = -(ty * o[3]); o[5] = div_round(64'($signed(w)), one);
      end
    end else if (a == 0 && d == 0) begin
      if (b == 0 || c == 0) sing = 1'b1;
      else begin
        o[1] = div_round(one2, c);
        o[2] = div_round(one2, b);
        w = -(ty * o[2]); o[4] = div_round(64'($signed(w)), one);
        w = -(tx * o[1]); o[5] = div_round(64'($signed(w)), one);
      end
    end else begin
      det = a * d - b * c;
      if (det == 0) sing = 1'b1;
      else begin
        o[0] = div_round(64'(d) * one2, det);
        o[1] = div_round(-(64'(b) * one2), det);
        o[2] = div_round(-(64'(c) * one2), det);
        o[3] = div_round(64'(a) * one2, det);
        o[4] = div_round(-(64'(tx) * 64'($signed(o[0])))
                         - 64'(ty) * 64'($signed(o[2])), one);
        o[5] = div_round(-(64'(tx) * 64'($signed(o[1])))
                         - 64'(ty) * 64'($signed(o[3])), one);
      end
    end
    res.sing = sing;
    res.data = sing ? '0 : {o[5], o[4], o[3], o[2], o[1], o[0]};
    return res;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    inverse_t want;
    if (!rst_ni) begin
      fails <= 0;
    end else begin
      if (s_valid_i && s_ready_i) inverse_q.push_back(invert(s_data_i));
      if (m_valid_i && m_ready_i) begin
        if (inverse_q.size() == 0) begin
          if (fails < 10) $display("unexpected result %h", m_data_i);
          fails <= fails + 1;
        end else begin
          want = inverse_q.pop_front();
          if (want.data !== m_data_i || want.sing !== m_user_i) begin
            if (fails < 10)
              $display("mismatch: exp sing=%b %h got sing=%b %h",
                       want.sing, want.data, m_user_i, m_data_i);
            fails <= fails + 1;
          end
        end
      end
    end
  end
endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int unsigned FracBits = 11;
  localparam int unsigned Latency  = 2 * FracBits + 39;
  localparam int unsigned NumRand  = 1150;
  localparam int unsigned Watchdog = 20000;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [ami_pkg::DataW-1:0] s_tdata = '0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [ami_pkg::DataW-1:0] m_tdata;
  logic                      m_tuser;
  int                        fail_count, pending, idle_cycles;
  bit                        quiet;

  always #4 clk_i = ~clk_i;

  affine_matrix_inverse_core #(.FRAC_BITS(FracBits)) dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready), .s_axis_tdata_i(s_tdata),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready),
    .m_axis_tdata_o(m_tdata), .m_axis_tuser_o(m_tuser)
  );

  ami_scoreboard #(.FRAC_BITS(FracBits)) u_checker (
    .clk_i, .rst_ni,
    .s_valid_i(s_tvalid), .s_ready_i(s_tready), .s_data_i(s_tdata),
    .m_valid_i(m_tvalid), .m_ready_i(m_tready), .m_data_i(m_tdata), .m_user_i(m_tuser),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    if (rst_ni) m_tready <= quiet || ($urandom_range(99) >= 10);
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > Watchdog) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return 32'($signed($urandom_range(8192)) - 4096);
      4: return 32'(1 << FracBits) * ($urandom_range(1) ? 32'hffff_ffff : 32'd1);
      default: return $urandom;
    endcase
  endfunction

  task automatic send(input logic [31:0] a, b, c, d, tx, ty);
    while (!quiet && $urandom_range(99) < 10) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {ty, tx, d, c, b, a};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  task automatic send_random();
    logic [31:0] e[6];
    for (int k = 0; k < 6; k++) e[k] = rand_elem();
    case ($urandom_range(5))
      0: begin e[1] = '0; e[2] = '0; end
      1: begin e[0] = '0; e[3] = '0; end
      2: begin e[2] = e[0] * e[3]; e[0] = e[1]; e[3] = 32'd1; end
      default: ;
    endcase
    send(e[0], e[1], e[2], e[3], e[4], e[5]);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  localparam logic [31:0] One = 32'd1 << FracBits;

  initial begin
    idle_cycles = 0;
    quiet = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send(One, 0, 0, One, 32'd5, 32'hffff_fff0);
    send(0, 0, 0, 0, 32'd7, 32'd9);
    send(0, 0, 0, One, 0, 0);
    send(0, One, 32'hffff_f800, 0, 32'd100, 32'd3);
    send(0, 0, One, 0, 32'd1, 32'd1);
    send(One, One, One, One, 32'd1, 32'd2);
    send(32'd3 * One, 32'd1, 32'd2, One, 32'h7fff_ffff, 32'h8000_0000);
    send(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, '1, '1);
    send(32'h7fff_ffff, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send(32'd1, 0, 0, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    send(0, 32'd1, 32'd1, 0, 32'h8000_0000, 32'h7fff_ffff);
    send(32'd3, 32'd2, 32'd2, 32'd1, 32'd11, 32'd13);
    send(32'h0001_0000, 32'h0001_0000, 32'h0000_0001, 32'h0000_0001, 0, 0);
    send('1, '1, '1, '1, '1, '1);
    drain();
    for (int i = 0; i < NumRand; i++) begin
      quiet = (i >= 300 && i < 500);
      if (i == 700) drain();
      send_random();
    end
    quiet = 1'b0;
    drain();
    repeat (Latency + 10) @(posedge clk_i);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
